[design/ctp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_pkg: shared types and constants of the counter program tokenizer
// holds token kinds, character codes, widths and the queue entry format
// ----------------------------------------------------------------------------
package ctp_pkg;

  // accumulator and line counter widths
  localparam int NUMBER_BITS  = 64;
  localparam int LINE_BITS    = 32;
  localparam int ACC_EXT_BITS = NUMBER_BITS + 4;

  // port field widths
  localparam int CH_BITS       = 8;
  localparam int KIND_BITS     = 4;
  localparam int OUT_NUM_BITS  = 64;
  localparam int OUT_LINE_BITS = 32;
  localparam int OUT_DATA_BITS = 112;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - CH_BITS - OUT_NUM_BITS - 1 - OUT_LINE_BITS;
  localparam int OUT_USER_BITS = KIND_BITS + 1;

  // decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [NUMBER_BITS-1:0]  num_t;
  typedef logic [ACC_EXT_BITS-1:0] acc_ext_t;
  typedef logic [LINE_BITS-1:0]    line_t;
  typedef logic [KIND_BITS-1:0]    kind_t;
  typedef logic [CH_BITS-1:0]      char_t;

  localparam num_t  NUM_MAX  = {NUMBER_BITS{1'b1}};
  localparam line_t LINE_MAX = {LINE_BITS{1'b1}};
  localparam line_t LINE_ONE = line_t'(1);

  // token kinds
  localparam kind_t KIND_NUMBER = 4'd0;
  localparam kind_t KIND_LABEL  = 4'd1;
  localparam kind_t KIND_INSTR  = 4'd2;
  localparam kind_t KIND_DOT    = 4'd3;
  localparam kind_t KIND_COLON  = 4'd4;
  localparam kind_t KIND_OPEN   = 4'd5;
  localparam kind_t KIND_CLOSE  = 4'd6;
  localparam kind_t KIND_COMMA  = 4'd7;
  localparam kind_t KIND_ERROR  = 4'd8;
  localparam kind_t KIND_END    = 4'd9;

  // character codes
  localparam char_t CH_DOT     = 8'h2E;
  localparam char_t CH_COLON   = 8'h3A;
  localparam char_t CH_OPEN    = 8'h28;
  localparam char_t CH_CLOSE   = 8'h29;
  localparam char_t CH_COMMA   = 8'h2C;
  localparam char_t CH_UNDER   = 8'h5F;
  localparam char_t CH_NEWLINE = 8'h0A;
  localparam char_t CH_TAB     = 8'h09;
  localparam char_t CH_CR      = 8'h0D;
  localparam char_t CH_SPACE   = 8'h20;
  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_NINE    = 8'h39;
  localparam char_t CH_LOW_A   = 8'h61;
  localparam char_t CH_LOW_Z   = 8'h7A;
  localparam char_t CH_UP_A    = 8'h41;
  localparam char_t CH_UP_Z    = 8'h5A;

  // one result without number payload
  typedef struct packed {
    logic  event_res;
    kind_t kind;
    char_t chv;
  } tok_res_t;

  // everything one character produces, one or two results
  typedef struct packed {
    logic     two;
    line_t    line;
    tok_res_t first;
    num_t     value;
    logic     ovf;
    tok_res_t second;
  } q_entry_t;

  // queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[design/ctp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_front: character classifier and token state
// accepts characters, tracks the open token, and queues its results
// ----------------------------------------------------------------------------
module ctp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  ctp_pkg::char_t       in_ch,
  input  logic                 in_eoi,
  input  ctp_pkg::q_status_t   q_stat,
  output logic                 push,
  output ctp_pkg::q_entry_t    push_entry
);

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_NUMBER = 6'b000010,
    MODE_LABEL  = 6'b000100,
    MODE_INSTR  = 6'b001000,
    MODE_HALTED = 6'b010000,
    MODE_ENDED  = 6'b100000
  } mode_t;

  mode_t                 mode_r, mode_nxt;
  ctp_pkg::num_t         acc_r, acc_nxt;
  logic                  ovf_r, ovf_nxt;
  ctp_pkg::line_t        line_r, line_nxt;

  logic                  accept, active, in_token;
  logic                  is_digit, is_lower, is_upper, is_space;
  logic [7:0]            ch_off;
  logic [3:0]            digit;
  ctp_pkg::acc_ext_t     acc_x10;
  logic                  acc_over;
  ctp_pkg::tok_res_t     close_res, start_res;
  logic                  start_has;
  logic [16:0]           cfg_line;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign active    = (mode_r != MODE_HALTED) && (mode_r != MODE_ENDED);
  assign in_token  = (mode_r == MODE_NUMBER) || (mode_r == MODE_LABEL) ||
                     (mode_r == MODE_INSTR);

  assign is_digit = (in_ch >= ctp_pkg::CH_ZERO)  && (in_ch <= ctp_pkg::CH_NINE);
  assign is_lower = (in_ch >= ctp_pkg::CH_LOW_A) && (in_ch <= ctp_pkg::CH_LOW_Z);
  assign is_upper = (in_ch >= ctp_pkg::CH_UP_A)  && (in_ch <= ctp_pkg::CH_UP_Z);
  assign is_space = (in_ch == ctp_pkg::CH_SPACE) ||
                    ((in_ch >= ctp_pkg::CH_TAB) && (in_ch <= ctp_pkg::CH_CR));

  assign ch_off = in_ch - ctp_pkg::CH_ZERO;
  assign digit  = ch_off[3:0];

  // acc*10 + d, carried wide so an overflow shows in the top bits
  assign acc_x10  = (ctp_pkg::acc_ext_t'(acc_r) << 3) + (ctp_pkg::acc_ext_t'(acc_r) << 1) +
                    ctp_pkg::acc_ext_t'(digit);
  assign acc_over = |acc_x10[ctp_pkg::ACC_EXT_BITS-1:ctp_pkg::NUMBER_BITS];

  // config load of the line counter, saturated to the counter width
  assign cfg_line = ({1'b0, cfg_wr_data} > 17'(ctp_pkg::LINE_MAX)) ?
                    17'(ctp_pkg::LINE_MAX) : {1'b0, cfg_wr_data};

  // result for the token that is open now
  always_comb begin
    close_res.event_res = 1'b1;
    close_res.chv       = '0;
    case (mode_r)
      MODE_NUMBER: close_res.kind = ctp_pkg::KIND_NUMBER;
      MODE_LABEL:  close_res.kind = ctp_pkg::KIND_LABEL;
      default:     close_res.kind = ctp_pkg::KIND_INSTR;
    endcase
  end

  // result for a character seen between tokens
  always_comb begin
    start_has           = 1'b1;
    start_res.event_res = 1'b1;
    start_res.chv       = in_ch;
    start_res.kind      = ctp_pkg::KIND_ERROR;
    if (is_space || is_digit) begin
      start_has = 1'b0;
    end else if (is_lower) begin
      start_res.event_res = 1'b0;
      start_res.kind      = ctp_pkg::KIND_LABEL;
    end else if (is_upper) begin
      start_res.event_res = 1'b0;
      start_res.kind      = ctp_pkg::KIND_INSTR;
    end else begin
      case (in_ch)
        ctp_pkg::CH_DOT:   start_res.kind = ctp_pkg::KIND_DOT;
        ctp_pkg::CH_COLON: start_res.kind = ctp_pkg::KIND_COLON;
        ctp_pkg::CH_OPEN:  start_res.kind = ctp_pkg::KIND_OPEN;
        ctp_pkg::CH_CLOSE: start_res.kind = ctp_pkg::KIND_CLOSE;
        ctp_pkg::CH_COMMA: start_res.kind = ctp_pkg::KIND_COMMA;
        default:           start_res.kind = ctp_pkg::KIND_ERROR;
      endcase
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    line_nxt   = line_r;
    push       = 1'b0;
    push_entry = '0;
    push_entry.line = line_r;

    if (cfg_wr_en) begin
      line_nxt = ctp_pkg::line_t'(cfg_line);
    end else if (accept && active) begin
      if (in_eoi) begin
        push     = 1'b1;
        mode_nxt = MODE_ENDED;
        acc_nxt  = '0;
        ovf_nxt  = 1'b0;
        if (in_token) begin
          push_entry.two              = 1'b1;
          push_entry.first            = close_res;
          push_entry.value            = (mode_r == MODE_NUMBER) ? acc_r : '0;
          push_entry.ovf              = (mode_r == MODE_NUMBER) && ovf_r;
          push_entry.second.event_res = 1'b1;
          push_entry.second.kind      = ctp_pkg::KIND_END;
        end else begin
          push_entry.first.event_res = 1'b1;
          push_entry.first.kind      = ctp_pkg::KIND_END;
        end
      end else if ((mode_r == MODE_NUMBER) && is_digit) begin
        if (acc_over) begin
          acc_nxt = ctp_pkg::NUM_MAX;
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = acc_x10[ctp_pkg::NUMBER_BITS-1:0];
        end
      end else if ((mode_r == MODE_LABEL) && (is_lower || (in_ch == ctp_pkg::CH_UNDER))) begin
        push                       = 1'b1;
        push_entry.first.event_res = 1'b0;
        push_entry.first.kind      = ctp_pkg::KIND_LABEL;
        push_entry.first.chv       = in_ch;
      end else if ((mode_r == MODE_INSTR) && is_upper) begin
        push                       = 1'b1;
        push_entry.first.event_res = 1'b0;
        push_entry.first.kind      = ctp_pkg::KIND_INSTR;
        push_entry.first.chv       = in_ch;
      end else begin
        // close the open token, then treat the character as a fresh start
        mode_nxt = MODE_IDLE;
        acc_nxt  = '0;
        ovf_nxt  = 1'b0;
        if (is_space) begin
          if ((in_ch == ctp_pkg::CH_NEWLINE) && (line_r != ctp_pkg::LINE_MAX)) begin
            line_nxt = line_r + ctp_pkg::LINE_ONE;
          end
        end else if (is_digit) begin
          mode_nxt = MODE_NUMBER;
          acc_nxt  = ctp_pkg::num_t'(digit);
        end else if (is_lower) begin
          mode_nxt = MODE_LABEL;
        end else if (is_upper) begin
          mode_nxt = MODE_INSTR;
        end else if (start_res.kind == ctp_pkg::KIND_ERROR) begin
          mode_nxt = MODE_HALTED;
        end
        if (in_token) begin
          push             = 1'b1;
          push_entry.first = close_res;
          push_entry.value = (mode_r == MODE_NUMBER) ? acc_r : '0;
          push_entry.ovf   = (mode_r == MODE_NUMBER) && ovf_r;
          push_entry.two   = start_has;
          push_entry.second = start_has ? start_res : '0;
        end else begin
          push             = start_has;
          push_entry.first = start_res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
      line_r <= ctp_pkg::LINE_ONE;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

[design/ctp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_queue: short queue between classifier and result sequencer
// holds the results of a few characters so each side stalls on its own
// ----------------------------------------------------------------------------
module ctp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ctp_pkg::q_entry_t    push_entry,
  input  logic                 pop,
  output ctp_pkg::q_entry_t    head,
  output ctp_pkg::q_status_t   q_stat
);

  ctp_pkg::q_entry_t               mem_r [ctp_pkg::QUEUE_DEPTH];
  logic [ctp_pkg::QPTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [ctp_pkg::QCNT_BITS-1:0]   count_r, count_nxt;

  assign q_stat.full  = (count_r == ctp_pkg::QCNT_BITS'(ctp_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

[design/ctp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_back: result sequencer
// splits each queued entry into one or two result beats in an output register
// ----------------------------------------------------------------------------
module ctp_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ctp_pkg::q_entry_t                      head,
  input  ctp_pkg::q_status_t                     q_stat,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [ctp_pkg::OUT_DATA_BITS-1:0]      out_tdata,
  output logic [ctp_pkg::OUT_USER_BITS-1:0]      out_tuser,
  output logic                                   out_tlast
);

  logic                                   valid_r;
  logic                                   sel_r;
  logic [ctp_pkg::OUT_DATA_BITS-1:0]      data_r, data_nxt;
  logic [ctp_pkg::OUT_USER_BITS-1:0]      user_r, user_nxt;
  logic                                   last_r, last_nxt;
  logic                                   load, take;
  ctp_pkg::tok_res_t                      res;
  ctp_pkg::num_t                          value;
  logic                                   ovf;

  assign load = !valid_r || out_tready;
  assign take = load && !q_stat.empty;
  assign pop  = take && last_nxt;

  always_comb begin
    if (sel_r) begin
      res   = head.second;
      value = '0;
      ovf   = 1'b0;
    end else begin
      res   = head.first;
      value = head.value;
      ovf   = head.ovf;
    end
    last_nxt = sel_r || !head.two;
    user_nxt = {res.kind, res.event_res};
    data_nxt = {{ctp_pkg::OUT_PAD_BITS{1'b0}},
                ctp_pkg::OUT_LINE_BITS'(head.line),
                ovf,
                ctp_pkg::OUT_NUM_BITS'(value),
                res.chv};
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= !q_stat.empty;
      end
      if (take) begin
        sel_r <= !last_nxt;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

[design/counter_program_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_program_tokenizer: lexical tokenizer for counter machine programs
// splits a character stream into numbers, labels, instruction names and
// punctuation, and reports each token with its line number
// ----------------------------------------------------------------------------
// One character request is taken per clock while the queue has room; a
// character that closes a token and also starts a punctuation or name token
// gives two result requests, which leave one after the other, so the output
// port sets the pace when results come in pairs. A classifier keeps
// the token state (open token kind, 64-bit number accumulator built by a
// shift-add each digit, line counter) and hands the results of each character
// to a four-deep queue; a sequencer drains it one result per cycle while the
// receiver is ready, through an output register, so the input keeps flowing
// while a result waits. A first_line write loads the line counter. After an
// error result or the end result the block swallows all further characters
// without result until reset. The user must write the first_line register
// only while the block is idle; the block itself does not enforce this.

module counter_program_tokenizer (
  input  logic          clk,
  input  logic          rst_n,
  // configuration: first line number
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  // character requests
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,    // [7:0] ch
  input  logic          in_tuser,    // [0] end_of_input
  // result requests
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,   // [7:0] char_value, [71:8] number_value,
                                     // [72] overflow, [104:73] line, rest zero
  output logic [4:0]    out_tuser,   // [0] event_res, [4:1] token_kind
  output logic          out_tlast    // last result of its character
);

  // queue handshake between classifier and sequencer
  logic                 push, pop;
  ctp_pkg::q_entry_t    push_entry, head;
  ctp_pkg::q_status_t   q_stat;

  // classifier: owns all token state, one character per cycle while the queue has room
  ctp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_ch      (in_tdata),
    .in_eoi     (in_tuser),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue, one entry per character that yields any result
  ctp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // sequencer: one or two result beats per entry
  ctp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

[design/ctp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_checker: port-level checks of the tokenizer
// watches the result channel for consistency of kinds, payload and framing
// ----------------------------------------------------------------------------
module ctp_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          out_tvalid,
  input  logic [111:0]  out_tdata,
  input  logic [4:0]    out_tuser,
  input  logic          out_tlast
);

  // no result request right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // character results only belong to name tokens
  a_char_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |->
      ((out_tuser[4:1] == ctp_pkg::KIND_LABEL) || (out_tuser[4:1] == ctp_pkg::KIND_INSTR)))
    else $error("character result with non-name kind");

  // only number results carry a value or overflow
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[4:1] != ctp_pkg::KIND_NUMBER)) |->
      ((out_tdata[71:8] == '0) && !out_tdata[72]))
    else $error("number payload on non-number result");

  // end and error results close out their character
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ((out_tuser[4:1] == ctp_pkg::KIND_END) ||
                    (out_tuser[4:1] == ctp_pkg::KIND_ERROR))) |-> out_tlast)
    else $error("end or error result not marked last");

endmodule

bind counter_program_tokenizer ctp_checker u_ctp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the counter program tokenizer
// streams program text through the character port, predicts every token
// result in a bench-side lexer and compares each result request field by field
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 12;      // quiet time before a register write
  localparam int LIMIT_CYCLES  = 200000;  // run aborts past this

  // whitespace codes the package does not name
  localparam ctp_pkg::char_t CH_VTAB = 8'h0B;
  localparam ctp_pkg::char_t CH_FF   = 8'h0C;

  // lexer modes of the bench-side prediction
  typedef enum logic [5:0] {
    LEX_IDLE   = 6'b000001,
    LEX_NUMBER = 6'b000010,
    LEX_LABEL  = 6'b000100,
    LEX_INSTR  = 6'b001000,
    LEX_HALTED = 6'b010000,
    LEX_ENDED  = 6'b100000
  } lex_mode_t;

  // one character request as queued for the driver
  typedef struct packed {
    logic           eoi;
    ctp_pkg::char_t ch;
  } char_req_t;

  // one predicted token result
  typedef struct {
    logic           event_res;
    ctp_pkg::kind_t kind;
    ctp_pkg::char_t chv;
    ctp_pkg::num_t  value;
    logic           ovf;
    ctp_pkg::line_t line;
    logic           last;
  } token_res_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_wr_en = 1'b0;
  logic [15:0]    cfg_wr_data = '0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [7:0]     in_tdata = '0;     // [7:0] ch
  logic           in_tuser = 1'b0;   // [0] end_of_input
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [111:0]   out_tdata;         // [7:0] char_value, [71:8] number_value,
                                     // [72] overflow, [104:73] line
  logic [4:0]     out_tuser;         // [0] event_res, [4:1] token_kind
  logic           out_tlast;

  // stimulus and expectation stores
  char_req_t  char_q[$];
  token_res_t token_q[$];
  char_req_t  next_char;
  int         queued_chars = 0;
  int         errors = 0;
  int         cycles = 0;

  // idle rates in percent, changed between phases
  int         send_idle_pct = 12;
  int         recv_idle_pct = 60;

  // receiver hold-off, toggled by the stimulus, counted in its own process
  logic       hold_req = 1'b0;
  logic       hold_ack = 1'b0;
  int         hold_left = 0;

  // bench-side lexer state and its copy of the register
  lex_mode_t      lex_mode = LEX_IDLE;
  ctp_pkg::num_t  lex_acc = '0;
  logic           lex_ovf = 1'b0;
  ctp_pkg::line_t lex_line = ctp_pkg::LINE_ONE;
  logic [15:0]    lex_first_line = 16'd1;

  counter_program_tokenizer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // bench-side lexer
  // ---------------------------------------------------------------------------
  function automatic logic is_digit(input ctp_pkg::char_t c);
    return c >= ctp_pkg::CH_ZERO && c <= ctp_pkg::CH_NINE;
  endfunction

  function automatic logic is_lower(input ctp_pkg::char_t c);
    return c >= ctp_pkg::CH_LOW_A && c <= ctp_pkg::CH_LOW_Z;
  endfunction

  function automatic logic is_upper(input ctp_pkg::char_t c);
    return c >= ctp_pkg::CH_UP_A && c <= ctp_pkg::CH_UP_Z;
  endfunction

  task automatic emit_token(input logic ev, input ctp_pkg::kind_t k, input ctp_pkg::char_t c,
                            input ctp_pkg::num_t v, input logic o);
    token_q.push_back('{ev, k, c, v, o, lex_line, 1'b0});
  endtask

  // an open token gives its end result, then the lexer is between tokens
  task automatic close_token();
    case (lex_mode)
      LEX_NUMBER: emit_token(1'b1, ctp_pkg::KIND_NUMBER, '0, lex_acc, lex_ovf);
      LEX_LABEL:  emit_token(1'b1, ctp_pkg::KIND_LABEL, '0, '0, 1'b0);
      LEX_INSTR:  emit_token(1'b1, ctp_pkg::KIND_INSTR, '0, '0, 1'b0);
      default:    ;
    endcase
    lex_mode = LEX_IDLE;
    lex_acc  = '0;
    lex_ovf  = 1'b0;
  endtask

  // character seen between tokens
  task automatic start_token(input ctp_pkg::char_t c);
    if (c == ctp_pkg::CH_SPACE || (c >= ctp_pkg::CH_TAB && c <= ctp_pkg::CH_CR)) begin
      if (c == ctp_pkg::CH_NEWLINE && lex_line < ctp_pkg::LINE_MAX)
        lex_line = lex_line + 1'b1;
    end else if (is_digit(c)) begin
      lex_mode = LEX_NUMBER;
      lex_acc  = ctp_pkg::num_t'(c - ctp_pkg::CH_ZERO);
      lex_ovf  = 1'b0;
    end else if (is_lower(c)) begin
      lex_mode = LEX_LABEL;
      emit_token(1'b0, ctp_pkg::KIND_LABEL, c, '0, 1'b0);
    end else if (is_upper(c)) begin
      lex_mode = LEX_INSTR;
      emit_token(1'b0, ctp_pkg::KIND_INSTR, c, '0, 1'b0);
    end else begin
      case (c)
        ctp_pkg::CH_DOT:   emit_token(1'b1, ctp_pkg::KIND_DOT, c, '0, 1'b0);
        ctp_pkg::CH_COLON: emit_token(1'b1, ctp_pkg::KIND_COLON, c, '0, 1'b0);
        ctp_pkg::CH_OPEN:  emit_token(1'b1, ctp_pkg::KIND_OPEN, c, '0, 1'b0);
        ctp_pkg::CH_CLOSE: emit_token(1'b1, ctp_pkg::KIND_CLOSE, c, '0, 1'b0);
        ctp_pkg::CH_COMMA: emit_token(1'b1, ctp_pkg::KIND_COMMA, c, '0, 1'b0);
        default: begin
          emit_token(1'b1, ctp_pkg::KIND_ERROR, c, '0, 1'b0);
          lex_mode = LEX_HALTED;
        end
      endcase
    end
  endtask

  // predict the results of one accepted character request
  task automatic lex_step(input ctp_pkg::char_t c, input logic eoi);
    int            n0;
    ctp_pkg::num_t d;
    n0 = token_q.size();
    d  = ctp_pkg::num_t'(c - ctp_pkg::CH_ZERO);
    if (lex_mode == LEX_HALTED || lex_mode == LEX_ENDED)
      return;
    if (eoi) begin
      close_token();
      emit_token(1'b1, ctp_pkg::KIND_END, '0, '0, 1'b0);
      lex_mode = LEX_ENDED;
    end else if (lex_mode == LEX_NUMBER && is_digit(c)) begin
      // saturate instead of wrapping past the accumulator range
      if (lex_acc > (ctp_pkg::NUM_MAX - d) / ctp_pkg::num_t'(10)) begin
        lex_acc = ctp_pkg::NUM_MAX;
        lex_ovf = 1'b1;
      end else begin
        lex_acc = lex_acc * ctp_pkg::num_t'(10) + d;
      end
    end else if (lex_mode == LEX_LABEL && (is_lower(c) || c == ctp_pkg::CH_UNDER)) begin
      emit_token(1'b0, ctp_pkg::KIND_LABEL, c, '0, 1'b0);
    end else if (lex_mode == LEX_INSTR && is_upper(c)) begin
      emit_token(1'b0, ctp_pkg::KIND_INSTR, c, '0, 1'b0);
    end else begin
      close_token();
      start_token(c);
    end
    if (token_q.size() > n0)
      token_q[token_q.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // driver: feeds char_q into the character port and predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      // register write seen by the block at this edge
      if (cfg_wr_en) begin
        lex_first_line = cfg_wr_data;
        lex_line       = ctp_pkg::line_t'(lex_first_line);
      end
      if (in_tvalid && in_tready)
        lex_step(in_tdata, in_tuser);
      // load the next request once the current one is gone
      if (!in_tvalid || in_tready) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_char = char_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_char.ch;
          in_tuser  <= next_char.eoi;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each result request with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    token_res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0h char %0h",
                   $time, out_tuser[4:1], out_tdata[7:0]);
          errors++;
        end else begin
          want = token_q.pop_front();
          check_field("event_res", 64'(want.event_res), 64'(out_tuser[0]));
          check_field("token_kind", 64'(want.kind), 64'(out_tuser[4:1]));
          check_field("char_value", 64'(want.chv), 64'(out_tdata[7:0]));
          check_field("number_value", want.value, out_tdata[71:8]);
          check_field("overflow", 64'(want.ovf), 64'(out_tdata[72]));
          check_field("line", 64'(want.line), 64'(out_tdata[104:73]));
          check_field("last", 64'(want.last), 64'(out_tlast));
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // long hold-off of the receiver, started by a toggle of hold_req
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_char(input ctp_pkg::char_t c, input logic eoi);
    char_q.push_back('{eoi, c});
    queued_chars++;
  endtask

  task automatic push_text(input string s);
    foreach (s[i])
      push_char(ctp_pkg::char_t'(s[i]), 1'b0);
  endtask

  // one random token or separator run of program text
  task automatic push_word(input int pick);
    case (pick)
      0, 1: begin
        repeat ($urandom_range(1, 6))
          push_char(ctp_pkg::char_t'($urandom_range(ctp_pkg::CH_ZERO, ctp_pkg::CH_NINE)),
                    1'b0);
      end
      2: begin
        // right at the accumulator limit, or a run at least as long as the limit that often overflows
        if ($urandom_range(0, 1)) begin
          push_text($sformatf("%0d", ctp_pkg::NUM_MAX));
        end else begin
          push_char(ctp_pkg::char_t'($urandom_range(ctp_pkg::CH_ZERO + 1, ctp_pkg::CH_NINE)),
                    1'b0);
          repeat ($urandom_range(19, 23))
            push_char(ctp_pkg::char_t'($urandom_range(ctp_pkg::CH_ZERO, ctp_pkg::CH_NINE)),
                      1'b0);
        end
      end
      3, 4: begin
        push_char(ctp_pkg::char_t'($urandom_range(ctp_pkg::CH_LOW_A, ctp_pkg::CH_LOW_Z)),
                  1'b0);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0)
            push_char(ctp_pkg::CH_UNDER, 1'b0);
          else
            push_char(ctp_pkg::char_t'($urandom_range(ctp_pkg::CH_LOW_A, ctp_pkg::CH_LOW_Z)),
                      1'b0);
        end
      end
      5, 6: begin
        repeat ($urandom_range(1, 6))
          push_char(ctp_pkg::char_t'($urandom_range(ctp_pkg::CH_UP_A, ctp_pkg::CH_UP_Z)),
                    1'b0);
      end
      7: begin
        case ($urandom_range(0, 4))
          0: push_char(ctp_pkg::CH_DOT, 1'b0);
          1: push_char(ctp_pkg::CH_COLON, 1'b0);
          2: push_char(ctp_pkg::CH_OPEN, 1'b0);
          3: push_char(ctp_pkg::CH_CLOSE, 1'b0);
          default: push_char(ctp_pkg::CH_COMMA, 1'b0);
        endcase
      end
      default: begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 7))
            0: push_char(ctp_pkg::CH_TAB, 1'b0);
            1: push_char(CH_VTAB, 1'b0);
            2: push_char(CH_FF, 1'b0);
            3: push_char(ctp_pkg::CH_CR, 1'b0);
            4, 5: push_char(ctp_pkg::CH_SPACE, 1'b0);
            default: push_char(ctp_pkg::CH_NEWLINE, 1'b0);
          endcase
        end
      end
    endcase
    // tokens often touch, so one token's end starts the next
    if ($urandom_range(0, 2) == 0)
      push_char($urandom_range(0, 1) ? ctp_pkg::CH_SPACE : ctp_pkg::CH_NEWLINE, 1'b0);
  endtask

  task automatic run_text(input int n);
    int stop_at;
    stop_at = queued_chars + n;
    while (queued_chars < stop_at)
      push_word($urandom_range(0, 9));
  endtask

  // sender pauses until every request is taken and every result is back;
  // checked between edges so the driver's updates have all landed
  task automatic drain_and_settle();
    @(negedge clk);
    while (char_q.size() != 0 || in_tvalid || token_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_first_line(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int stop_at;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed text with the reset line number: label with underscore, every
    // punctuation mark, every whitespace code, digit and letter extremes,
    // a label ended by a digit, a newline that closes a number
    push_text("a_z:ZA(09)");
    push_char(ctp_pkg::CH_TAB, 1'b0);
    push_text(".");
    push_char(CH_VTAB, 1'b0);
    push_text(",");
    push_char(CH_FF, 1'b0);
    push_char(ctp_pkg::CH_CR, 1'b0);
    push_text(" q5");
    push_char(ctp_pkg::CH_NEWLINE, 1'b0);
    push_text("0 PUSH:");

    // sender idles rarely, receiver often, first line at zero
    drain_and_settle();
    write_first_line(16'd0);
    run_text(130);

    // the other way round, first line at its top
    drain_and_settle();
    write_first_line(16'hFFFF);
    send_idle_pct <= 60;
    recv_idle_pct <= 12;
    run_text(130);

    // no idling; receiver holds off while a run of name characters piles up
    drain_and_settle();
    write_first_line(16'($urandom_range(2, 65534)));
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_req <= ~hold_req;
    stop_at = queued_chars + 40;
    while (queued_chars < stop_at)
      push_word($urandom_range(3, 6));
    run_text(90);

    // back to the reset value, then close the stream for good: either an end
    // mark with a token still open or an unexpected character
    drain_and_settle();
    write_first_line(16'd1);
    push_text("x9");
    if ($urandom_range(0, 1)) begin
      push_char(ctp_pkg::char_t'($urandom), 1'b1);
    end else begin
      case ($urandom_range(0, 2))
        0: push_char(ctp_pkg::char_t'($urandom_range(128, 255)), 1'b0);
        1: push_char(ctp_pkg::char_t'($urandom_range(0, ctp_pkg::CH_TAB - 1)), 1'b0);
        default: push_char(ctp_pkg::char_t'($urandom_range(ctp_pkg::CH_CR + 1,
                                                            ctp_pkg::CH_SPACE - 1)), 1'b0);
      endcase
    end
    // everything after that is swallowed without result
    repeat (24)
      push_char(ctp_pkg::char_t'($urandom), 1'($urandom_range(0, 1)));

    drain_and_settle();
    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
